// ===== sv/ocia_pkg.sv =====
// Package: opcodes, widths and status codes for the checked integer ALU.
package ocia_pkg;
	localparam int WIDE_BITS_DEF = 32;
	localparam int NARROW_BITS_DEF = 16;
	localparam int MODE_W = 5;
	localparam int OUT_W = 32;

	localparam logic [4:0] OP_ADD = 5'd0;
	localparam logic [4:0] OP_SUB = 5'd1;
	localparam logic [4:0] OP_MUL = 5'd2;
	localparam logic [4:0] OP_DIV = 5'd3;
	localparam logic [4:0] OP_MOD = 5'd4;
	localparam logic [4:0] OP_NEG = 5'd5;
	localparam logic [4:0] OP_ABS = 5'd6;
	localparam logic [4:0] OP_INC = 5'd7;
	localparam logic [4:0] OP_MAX = 5'd8;
	localparam logic [4:0] OP_MIN = 5'd9;
	localparam logic [4:0] OP_AND = 5'd10;
	localparam logic [4:0] OP_OR  = 5'd11;
	localparam logic [4:0] OP_XOR = 5'd12;
	localparam logic [4:0] OP_NOT = 5'd13;
	localparam logic [4:0] OP_SHL = 5'd14;
	localparam logic [4:0] OP_SHR = 5'd15;
	localparam logic [4:0] OP_EQ  = 5'd16;
	localparam logic [4:0] OP_NE  = 5'd17;
	localparam logic [4:0] OP_LT  = 5'd18;
	localparam logic [4:0] OP_LE  = 5'd19;
	localparam logic [4:0] OP_GT  = 5'd20;
	localparam logic [4:0] OP_GE  = 5'd21;
	localparam logic [4:0] OP_NARROW = 5'd22;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;
endpackage

// ===== sv/overflow_checked_integer_alu_core.sv =====
// Top level: overflow-checked integer ALU, pipelined.
//  channel | signals                                                   | dir
//  in      | in_valid in_stall mode left_operand right_operand          | in
//          | left_is_wide right_is_wide                                |
//  out     | out_valid out_stall value result_is_wide status           | out
// One item enters per cycle unless in_stall holds the input. The whole pipe
// advances together; out_stall freezes every stage while out_valid is high,
// so in_stall follows out_stall while the pipe holds a result. Reset clears
// the valid bits only.
module overflow_checked_integer_alu_core #(
	parameter int WIDE_BITS = ocia_pkg::WIDE_BITS_DEF,
	parameter int NARROW_BITS = ocia_pkg::NARROW_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  mode,
	input  logic signed [31:0] left_operand,
	input  logic signed [31:0] right_operand,
	input  logic        left_is_wide,
	input  logic        right_is_wide,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] value,
	output logic        result_is_wide,
	output logic [1:0]  status
);
	localparam int W = WIDE_BITS;
	localparam int EW = 2*W + 2;
	localparam int DL = W;

	logic en;
	assign en = ~(out_valid & out_stall);
	assign in_stall = ~en;

	// stage 1: operand extension
	logic [4:0] md_s1;
	logic wd_s1, v_s1;
	logic signed [W-1:0] a_s1, b_s1;

	function automatic logic signed [W-1:0] ext_op(input logic [31:0] x, input logic wide);
		logic signed [W-1:0] r;
		logic [NARROW_BITS-1:0] n;
		logic [W-1:0] xw;
		begin
			xw = W'($signed(x));
			n = xw[NARROW_BITS-1:0];
			r = wide ? $signed(xw) : W'($signed(n));
			return r;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			md_s1 <= mode;
			a_s1 <= ext_op(left_operand, left_is_wide);
			b_s1 <= ext_op(right_operand, right_is_wide);
			if ((mode >= ocia_pkg::OP_NEG && mode <= ocia_pkg::OP_INC) ||
			    mode == ocia_pkg::OP_NOT || mode == ocia_pkg::OP_SHL ||
			    mode == ocia_pkg::OP_SHR)
				wd_s1 <= left_is_wide;
			else if (mode == ocia_pkg::OP_NARROW)
				wd_s1 <= 1'b0;
			else
				wd_s1 <= left_is_wide | right_is_wide;
		end
	end

	// stage 2: simple ops at extended width, multiply, divider launch
	logic v_s2, wd_s2, dz_s2;
	logic [4:0] md_s2;
	logic signed [EW-1:0] r_s2;
	logic sa_s2, sb_s2;

	logic signed [EW-1:0] ea, eb, rs;
	logic [W-1:0] ma, mb;
	logic [4:0] cnt;
	assign ea = EW'(a_s1);
	assign eb = EW'(b_s1);
	assign ma = a_s1[W-1] ? W'(-a_s1) : W'(a_s1);
	assign mb = b_s1[W-1] ? W'(-b_s1) : W'(b_s1);
	assign cnt = b_s1[4:0];

	always_comb begin
		logic signed [EW-1:0] sh;
		sh = '0;
		rs = '0;
		case (md_s1)
			ocia_pkg::OP_ADD: rs = ea + eb;
			ocia_pkg::OP_SUB: rs = ea - eb;
			ocia_pkg::OP_NEG: rs = -ea;
			ocia_pkg::OP_ABS: rs = ea[EW-1] ? -ea : ea;
			ocia_pkg::OP_INC: rs = ea + EW'(1);
			ocia_pkg::OP_MAX: rs = (a_s1 < b_s1) ? eb : ea;
			ocia_pkg::OP_MIN: rs = (b_s1 < a_s1) ? eb : ea;
			ocia_pkg::OP_AND: rs = ea & eb;
			ocia_pkg::OP_OR:  rs = ea | eb;
			ocia_pkg::OP_XOR: rs = ea ^ eb;
			ocia_pkg::OP_NOT: rs = ~ea;
			ocia_pkg::OP_SHL: begin
				sh = ea <<< cnt;
				if (wd_s1)
					rs = EW'($signed(sh[W-1:0]));
				else
					rs = EW'($signed(sh[NARROW_BITS-1:0]));
			end
			ocia_pkg::OP_SHR: rs = ea >>> cnt;
			ocia_pkg::OP_EQ: rs = EW'(a_s1 == b_s1);
			ocia_pkg::OP_NE: rs = EW'(a_s1 != b_s1);
			ocia_pkg::OP_LT: rs = EW'(a_s1 < b_s1);
			ocia_pkg::OP_LE: rs = EW'(!(b_s1 < a_s1));
			ocia_pkg::OP_GT: rs = EW'(b_s1 < a_s1);
			ocia_pkg::OP_GE: rs = EW'(!(a_s1 < b_s1));
			ocia_pkg::OP_NARROW: rs = ea;
			default: rs = '0;
		endcase
	end

	logic [2*W-1:0] prod_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			md_s2 <= md_s1;
			wd_s2 <= wd_s1;
			r_s2 <= rs;
			prod_s2 <= ma * mb;
			sa_s2 <= a_s1[W-1];
			sb_s2 <= b_s1[W-1];
			dz_s2 <= (b_s1 == '0);
		end
	end

	// stage 3: signed product
	logic v_s3, wd_s3, dz_s3, sa_s3, sb_s3;
	logic [4:0] md_s3;
	logic signed [EW-1:0] r_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			md_s3 <= md_s2;
			wd_s3 <= wd_s2;
			dz_s3 <= dz_s2;
			sa_s3 <= sa_s2;
			sb_s3 <= sb_s2;
			if (md_s2 == ocia_pkg::OP_MUL)
				r_s3 <= (sa_s2 ^ sb_s2) ? -$signed(EW'(prod_s2)) : $signed(EW'(prod_s2));
			else
				r_s3 <= r_s2;
		end
	end

	// divider runs alongside the main pipe
	logic [W-1:0] dq, dr;
	// Keep the divider aligned with stage 1 data; the rest of the pipe is
	// delayed through a matching shift line below.
	ocia_divider #(.W(W)) u_div (
		.clk(clk), .en(en), .num(ma), .den(mb),
		.quo(dq), .rem(dr)
	);

	// delay stage-3 results by DL-2 stages so they meet the divider output
	logic [EW-1:0] dly_r [0:DL-2];
	logic [4:0] dly_md [0:DL-2];
	logic dly_wd [0:DL-2];
	logic dly_dz [0:DL-2];
	logic dly_sa [0:DL-2];
	logic dly_sb [0:DL-2];
	logic dly_v [0:DL-2];
	assign dly_r[0] = r_s3;
	assign dly_md[0] = md_s3;
	assign dly_wd[0] = wd_s3;
	assign dly_dz[0] = dz_s3;
	assign dly_sa[0] = sa_s3;
	assign dly_sb[0] = sb_s3;
	assign dly_v[0] = v_s3;
	for (genvar k = 0; k < DL-2; k++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dly_v[k+1] <= 1'b0;
			end else if (en) begin
				dly_v[k+1] <= dly_v[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dly_r[k+1] <= dly_r[k];
				dly_md[k+1] <= dly_md[k];
				dly_wd[k+1] <= dly_wd[k];
				dly_dz[k+1] <= dly_dz[k];
				dly_sa[k+1] <= dly_sa[k];
				dly_sb[k+1] <= dly_sb[k];
			end
		end
	end

	// final stage: choose, range-check, register
	logic signed [EW-1:0] fr;
	logic [1:0] fst;
	logic fwd;
	always_comb begin
		logic [4:0] m;
		logic signed [EW-1:0] x;
		logic ok;
		m = dly_md[DL-2];
		x = dly_r[DL-2];
		fwd = dly_wd[DL-2];
		fst = ocia_pkg::ST_OK;
		if (m == ocia_pkg::OP_DIV)
			x = (dly_sa[DL-2] ^ dly_sb[DL-2]) ? -$signed(EW'(dq)) : $signed(EW'(dq));
		else if (m == ocia_pkg::OP_MOD)
			x = dly_sa[DL-2] ? -$signed(EW'(dr)) : $signed(EW'(dr));
		if (fwd)
			ok = (x == EW'($signed(x[W-1:0])));
		else
			ok = (x == EW'($signed(x[NARROW_BITS-1:0])));
		if ((m == ocia_pkg::OP_DIV || m == ocia_pkg::OP_MOD) && dly_dz[DL-2])
			fst = ocia_pkg::ST_DIVZ;
		else if (!ok)
			fst = ocia_pkg::ST_OVF;
		fr = (fst == ocia_pkg::ST_OK) ? x : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dly_v[DL-2];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			value <= 32'(fr);
			result_is_wide <= fwd;
			status <= fst;
		end
	end
endmodule

// ===== sv/ocia_divider.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
module ocia_divider #(
	parameter int W = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [W-1:0]  num,
	input  logic [W-1:0]  den,
	output logic [W-1:0]  quo,
	output logic [W-1:0]  rem
);
	logic [W-1:0]  rem_r [0:W];
	logic [W-1:0]  num_r [0:W];
	logic [W-1:0]  den_r [0:W];

	assign rem_r[0] = '0;
	assign num_r[0] = num;
	assign den_r[0] = den;

	for (genvar i = 0; i < W; i++) begin : g_st
		logic [W:0] trial;
		logic [W:0] diff;
		assign trial = {rem_r[i], num_r[i][W-1]};
		assign diff = trial - {1'b0, den_r[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_r[i+1] <= diff[W] ? trial[W-1:0] : diff[W-1:0];
				num_r[i+1] <= {num_r[i][W-2:0], ~diff[W]};
				den_r[i+1] <= den_r[i];
			end
		end
	end

	assign quo = num_r[W];
	assign rem = rem_r[W];
endmodule
